/* src/rexg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rexg_pkg
// Types, codes and constants shared by the relay expander guard.
// ----------------------------------------------------------------------------
package rexg_pkg;

    localparam logic [3:0] LAST_OUTPUT_CHANNEL = 4'd7;
    localparam logic [3:0] LAST_VALID_CHANNEL  = 4'd15;
    localparam logic [3:0] FIRST_INPUT_CHANNEL = 4'd8;
    localparam logic [7:0] ERR_MAX             = 8'hFF;
    localparam logic [7:0] SHADOW_RESET        = 8'hFF;
    localparam logic [2:0] SHIFT_MAX           = 3'd6;
    localparam logic [15:0] RETRY_BASE_RESET   = 16'd500;
    localparam logic [31:0] RETRY_MAX_RESET    = 32'd30000;

    typedef enum logic [2:0] {
        KIND_INIT       = 3'd0,
        KIND_QUERY      = 3'd1,
        KIND_WRITE      = 3'd2,
        KIND_READ_CH    = 3'd3,
        KIND_READ_ALL   = 3'd4,
        KIND_ALL_SAFE   = 3'd5,
        KIND_LATCH_SAFE = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        REG_ACTIVE_LOW = 2'd0,
        REG_SAFE_ON    = 2'd1,
        REG_RETRY_BASE = 2'd2,
        REG_RETRY_MAX  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ms;
        logic [3:0]  channel;
        logic        turn_on;
        logic        init_ok;
        logic        access_ok;
        logic [7:0]  port_b_value;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic [15:0] read_value;
        logic        latch_write;
        logic [7:0]  latch_byte;
        logic        init_issued;
    } result_t;

    typedef struct packed {
        logic        energize_low;
        logic        relay_safe_on;
        logic [15:0] retry_base_ms;
        logic [31:0] retry_max_ms;
    } cfg_t;

    typedef struct packed {
        logic        device_present;
        logic [7:0]  error_count;
        logic [31:0] next_probe_time;
        logic [7:0]  output_shadow;
        logic        safe_latched;
    } state_t;

    function automatic logic [7:0] phys_of_logical(input logic [7:0] logical,
                                                   input logic active_low);
        return active_low ? ~logical : logical;
    endfunction

    function automatic logic [31:0] backoff_delay(input logic [7:0] errs,
                                                  input logic [15:0] base,
                                                  input logic [31:0] max_ms);
        logic [2:0]  sh;
        logic [31:0] d;
        if (errs > 8'(SHIFT_MAX))
            sh = SHIFT_MAX;
        else if (errs != 8'd0)
            sh = 3'(errs - 8'd1);
        else
            sh = 3'd0;
        d = {16'd0, base} << sh;
        return (d < max_ms) ? d : max_ms;
    endfunction

endpackage

/* src/rexg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rexg_req_if / rexg_rsp_if
// Valid/ready channels for operation requests and their results.
// ----------------------------------------------------------------------------
interface rexg_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] now_ms;
    logic [3:0]  channel;
    logic        turn_on;
    logic        init_ok;
    logic        access_ok;
    logic [7:0]  port_b_value;

    modport source (output valid, kind, now_ms, channel, turn_on, init_ok, access_ok,
                    port_b_value, input ready);
    modport sink   (input valid, kind, now_ms, channel, turn_on, init_ok, access_ok,
                    port_b_value, output ready);
endinterface

interface rexg_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [15:0] read_value;
    logic        latch_write;
    logic [7:0]  latch_byte;
    logic        init_issued;

    modport source (output valid, ok, read_value, latch_write, latch_byte, init_issued,
                    input ready);
    modport sink   (input valid, ok, read_value, latch_write, latch_byte, init_issued,
                    output ready);
endinterface

/* src/rexg_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rexg_core
// Single-pass operation logic: presence check, bus outcome, backoff, shadow.
// ----------------------------------------------------------------------------
module rexg_core (
    input  rexg_pkg::item_t   item,
    input  rexg_pkg::cfg_t    cfg,
    input  rexg_pkg::state_t  st,
    output rexg_pkg::state_t  st_next,
    output rexg_pkg::result_t res
);

    logic [7:0] safe_byte;

    assign safe_byte = rexg_pkg::phys_of_logical({8{cfg.relay_safe_on}},
                                                 cfg.energize_low);

    always_comb
    begin
        logic        present;
        logic [7:0]  err;
        logic [31:0] dl;
        logic [7:0]  shadow;
        logic        latched;
        logic        do_check;
        logic        pass;
        logic        fail;
        logic        reached;
        logic [31:0] diff;
        logic [7:0]  bitmask;
        logic [7:0]  want;
        logic        high;
        logic [2:0]  in_idx;
        logic [7:0]  logical;

        present  = st.device_present;
        err      = st.error_count;
        dl       = st.next_probe_time;
        shadow   = st.output_shadow;
        latched  = st.safe_latched;
        res      = '0;
        pass     = 1'b0;
        fail     = 1'b0;
        do_check = 1'b0;
        bitmask  = 8'(1) << item.channel[2:0];
        high     = cfg.energize_low ? !item.turn_on : item.turn_on;
        want     = high ? (shadow | bitmask) : (shadow & ~bitmask);
        in_idx   = 3'(item.channel - rexg_pkg::FIRST_INPUT_CHANNEL);

        if (item.kind == rexg_pkg::KIND_INIT)
        begin
            present = 1'b0;
            err     = 8'd0;
            dl      = 32'd0;
        end

        case (item.kind)
            rexg_pkg::KIND_INIT, rexg_pkg::KIND_QUERY, rexg_pkg::KIND_READ_ALL,
            rexg_pkg::KIND_ALL_SAFE, rexg_pkg::KIND_LATCH_SAFE:
                do_check = 1'b1;
            rexg_pkg::KIND_WRITE:
                do_check = !(item.channel > rexg_pkg::LAST_OUTPUT_CHANNEL ||
                             (item.turn_on && latched));
            rexg_pkg::KIND_READ_CH:
                do_check = !(item.channel > rexg_pkg::LAST_VALID_CHANNEL);
            default:
                do_check = 1'b0;
        endcase

        if (item.kind == rexg_pkg::KIND_LATCH_SAFE)
            latched = 1'b1;

        diff    = item.now_ms - dl;
        reached = !diff[31];

        // presence check, with init attempt when due or forced
        if (do_check)
        begin
            if (present)
                pass = 1'b1;
            else if (item.kind == rexg_pkg::KIND_INIT || reached)
            begin
                res.init_issued = 1'b1;
                if (item.init_ok)
                begin
                    shadow          = safe_byte;
                    res.latch_write = 1'b1;
                    res.latch_byte  = safe_byte;
                    present         = 1'b1;
                    err             = 8'd0;
                    dl              = 32'd0;
                    pass            = 1'b1;
                end
                else
                    fail = 1'b1;
            end
        end

        logical = rexg_pkg::phys_of_logical(shadow, cfg.energize_low);
        want    = high ? (shadow | bitmask) : (shadow & ~bitmask);

        if (pass)
        begin
            case (item.kind)
                rexg_pkg::KIND_INIT, rexg_pkg::KIND_QUERY:
                    res.ok = 1'b1;
                rexg_pkg::KIND_WRITE:
                    if (item.access_ok)
                    begin
                        shadow          = want;
                        res.latch_write = 1'b1;
                        res.latch_byte  = want;
                        present         = 1'b1;
                        err             = 8'd0;
                        dl              = 32'd0;
                        res.ok          = 1'b1;
                    end
                    else
                        fail = 1'b1;
                rexg_pkg::KIND_READ_CH:
                    if (item.channel <= rexg_pkg::LAST_OUTPUT_CHANNEL)
                    begin
                        res.read_value = {15'd0, logical[item.channel[2:0]]};
                        res.ok         = 1'b1;
                    end
                    else if (item.access_ok)
                    begin
                        res.read_value = {15'd0, item.port_b_value[in_idx]};
                        present        = 1'b1;
                        err            = 8'd0;
                        dl             = 32'd0;
                        res.ok         = 1'b1;
                    end
                    else
                        fail = 1'b1;
                rexg_pkg::KIND_READ_ALL:
                    if (item.access_ok)
                    begin
                        res.read_value = {item.port_b_value, logical};
                        present        = 1'b1;
                        err            = 8'd0;
                        dl             = 32'd0;
                        res.ok         = 1'b1;
                    end
                    else
                        fail = 1'b1;
                rexg_pkg::KIND_ALL_SAFE, rexg_pkg::KIND_LATCH_SAFE:
                    if (item.access_ok)
                    begin
                        shadow          = safe_byte;
                        res.latch_write = 1'b1;
                        res.latch_byte  = safe_byte;
                        present         = 1'b1;
                        err             = 8'd0;
                        dl              = 32'd0;
                        res.ok          = 1'b1;
                    end
                    else
                        fail = 1'b1;
                default:
                    res.ok = 1'b0;
            endcase
        end

        // one failure per item at most: check or transfer
        if (fail)
        begin
            present = 1'b0;
            if (err != rexg_pkg::ERR_MAX)
                err = err + 8'd1;
            dl = item.now_ms + rexg_pkg::backoff_delay(err, cfg.retry_base_ms,
                                                       cfg.retry_max_ms);
        end

        st_next.device_present  = present;
        st_next.error_count     = err;
        st_next.next_probe_time = dl;
        st_next.output_shadow   = shadow;
        st_next.safe_latched    = latched;
    end

endmodule

/* src/relay_expander_guard_with_backoff.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_expander_guard_with_backoff
// Guards a relay/input expander: presence tracking, retry backoff, output
// shadow and safe latch, one operation request per cycle unless rsp stalls.
//
//  channel  dir   handshake      payload
//  req      in    valid/ready    kind, now_ms, channel, turn_on, init_ok,
//                                access_ok, port_b_value
//  rsp      out   valid/ready    ok, read_value, latch_write, latch_byte,
//                                init_issued
//  cfg      in    cfg_wr_en      cfg_index, cfg_wdata
//
//  One request per cycle sustained unless rsp stalls (via the input register,
//  then the result register loaded by the single-pass operation logic).
//  State updates as a request leaves the input register.
//  Reset is asynchronous, active low; all but the item and result registers
//  return to defaults. A stalled rsp holds its result; req is ready while the
//  input register is empty or moves into a free or draining result register.
// ----------------------------------------------------------------------------
module relay_expander_guard_with_backoff (
    input  logic               clk,
    input  logic               rst_n,
    rexg_req_if.sink           req,
    rexg_rsp_if.source         rsp,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);

    logic                s1_valid_reg;
    rexg_pkg::item_t     s1_item_reg;
    logic                out_valid_reg;
    rexg_pkg::result_t   out_res_reg;
    rexg_pkg::cfg_t      cfg_reg;
    rexg_pkg::state_t    st_reg;
    rexg_pkg::state_t    st_next;
    rexg_pkg::result_t   res_next;
    rexg_pkg::item_t     req_item;
    logic                out_free;
    logic                s1_fire;
    logic                req_fire;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign req_fire  = req.valid && req.ready;

    assign req_item.kind         = req.kind;
    assign req_item.now_ms       = req.now_ms;
    assign req_item.channel      = req.channel;
    assign req_item.turn_on      = req.turn_on;
    assign req_item.init_ok      = req.init_ok;
    assign req_item.access_ok    = req.access_ok;
    assign req_item.port_b_value = req.port_b_value;

    rexg_core u_core (
        .item    (s1_item_reg),
        .cfg     (cfg_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg                 <= 1'b0;
            out_valid_reg                <= 1'b0;
            cfg_reg.energize_low         <= 1'b1;
            cfg_reg.relay_safe_on        <= 1'b0;
            cfg_reg.retry_base_ms        <= rexg_pkg::RETRY_BASE_RESET;
            cfg_reg.retry_max_ms         <= rexg_pkg::RETRY_MAX_RESET;
            st_reg.device_present        <= 1'b0;
            st_reg.error_count           <= 8'd0;
            st_reg.next_probe_time       <= 32'd0;
            st_reg.output_shadow         <= rexg_pkg::SHADOW_RESET;
            st_reg.safe_latched          <= 1'b0;
        end
        else
        begin
            if (req.ready)
                s1_valid_reg <= req.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (s1_fire)
                st_reg <= st_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    rexg_pkg::REG_ACTIVE_LOW: cfg_reg.energize_low     <= cfg_wdata[0];
                    rexg_pkg::REG_SAFE_ON:    cfg_reg.relay_safe_on    <= cfg_wdata[0];
                    rexg_pkg::REG_RETRY_BASE: cfg_reg.retry_base_ms    <= cfg_wdata[15:0];
                    rexg_pkg::REG_RETRY_MAX:  cfg_reg.retry_max_ms     <= cfg_wdata;
                    default:                  cfg_reg.relay_safe_on    <= cfg_reg.relay_safe_on;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
            s1_item_reg <= req_item;
        if (s1_fire)
            out_res_reg <= res_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.ok          = out_res_reg.ok;
    assign rsp.read_value  = out_res_reg.read_value;
    assign rsp.latch_write = out_res_reg.latch_write;
    assign rsp.latch_byte  = out_res_reg.latch_byte;
    assign rsp.init_issued = out_res_reg.init_issued;

    a_latch_shadow: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res_next.latch_write |=> st_reg.output_shadow == $past(res_next.latch_byte))
        else $error("shadow does not follow latch write");

    a_present_clean: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.device_present |-> st_reg.error_count == 8'd0 &&
                                  st_reg.next_probe_time == 32'd0)
        else $error("present with pending error state");

    a_ok_present: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && res_next.ok |=> st_reg.device_present)
        else $error("success without presence");

    a_safe_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.safe_latched |=> st_reg.safe_latched)
        else $error("safe latch released");

    a_no_init_when_present: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && st_reg.device_present && s1_item_reg.kind != rexg_pkg::KIND_INIT
        |-> !res_next.init_issued)
        else $error("init issued while present");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for relay_expander_guard_with_backoff. A directed opening covers
// presence probing, backoff and wrap of the probe deadline, writes, reads and
// the safe pattern. Random phases under several register settings follow:
// a healthy bus, a flaky bus across the time wrap, a dead device that drives
// up the error count, maximal and zero retry values, and the safe latch.
// A scoreboard class predicts every request's result and checks the results
// in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] KIND_UNUSED  = 3'd7;
    localparam int         LIMIT_CYCLES = 400000;

    class relay_guard_scoreboard;
        rexg_pkg::cfg_t    cfg;
        rexg_pkg::state_t  st;
        rexg_pkg::result_t cur;
        rexg_pkg::result_t expected_results[$];
        int                fail_count;
        int                result_seq;

        function new();
            cfg.energize_low     = 1'b1;
            cfg.relay_safe_on    = 1'b0;
            cfg.retry_base_ms    = rexg_pkg::RETRY_BASE_RESET;
            cfg.retry_max_ms     = rexg_pkg::RETRY_MAX_RESET;
            st.device_present    = 1'b0;
            st.error_count       = 8'd0;
            st.next_probe_time   = 32'd0;
            st.output_shadow     = rexg_pkg::SHADOW_RESET;
            st.safe_latched      = 1'b0;
            fail_count           = 0;
            result_seq           = 0;
        endfunction

        function void write_reg(rexg_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                rexg_pkg::REG_ACTIVE_LOW: cfg.energize_low     = value[0];
                rexg_pkg::REG_SAFE_ON:    cfg.relay_safe_on    = value[0];
                rexg_pkg::REG_RETRY_BASE: cfg.retry_base_ms    = value[15:0];
                rexg_pkg::REG_RETRY_MAX:  cfg.retry_max_ms     = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] to_pin(logic [7:0] logical);
            return cfg.energize_low ? ~logical : logical;
        endfunction

        function logic [7:0] safe_pattern();
            return to_pin(cfg.relay_safe_on ? 8'hFF : 8'h00);
        endfunction

        function logic [31:0] retry_delay(logic [7:0] errs);
            logic [2:0]  sh;
            logic [31:0] d;
            if (errs > 8'(rexg_pkg::SHIFT_MAX))
                sh = rexg_pkg::SHIFT_MAX;
            else if (errs != 8'd0)
                sh = 3'(errs - 8'd1);
            else
                sh = 3'd0;
            d  = {16'd0, cfg.retry_base_ms} << sh;
            return (d < cfg.retry_max_ms) ? d : cfg.retry_max_ms;
        endfunction

        function void mark_failure(logic [31:0] now);
            st.device_present = 1'b0;
            if (st.error_count != rexg_pkg::ERR_MAX)
                st.error_count = st.error_count + 8'd1;
            st.next_probe_time = now + retry_delay(st.error_count);
        endfunction

        function void mark_success();
            st.device_present  = 1'b1;
            st.error_count     = 8'd0;
            st.next_probe_time = 32'd0;
        endfunction

        function void drive_latch(logic [7:0] pins);
            st.output_shadow = pins;
            cur.latch_write  = 1'b1;
            cur.latch_byte   = pins;
        endfunction

        function bit probe(logic [31:0] now, bit forced, bit init_ack);
            logic [31:0] since;
            if (st.device_present)
                return 1'b1;
            since = now - st.next_probe_time;
            if (!forced && since[31])
                return 1'b0;
            cur.init_issued = 1'b1;
            if (!init_ack)
            begin
                mark_failure(now);
                return 1'b0;
            end
            drive_latch(safe_pattern());
            mark_success();
            return 1'b1;
        endfunction

        function void note_request(rexg_pkg::item_t it);
            logic [7:0] mask;
            logic [7:0] logical;
            bit         level;
            cur = '0;
            case (it.kind)
                rexg_pkg::KIND_INIT:
                begin
                    st.device_present  = 1'b0;
                    st.error_count     = 8'd0;
                    st.next_probe_time = 32'd0;
                    cur.ok = probe(it.now_ms, 1'b1, it.init_ok);
                end
                rexg_pkg::KIND_QUERY:
                    cur.ok = probe(it.now_ms, 1'b0, it.init_ok);
                rexg_pkg::KIND_WRITE:
                begin
                    if (it.channel <= rexg_pkg::LAST_OUTPUT_CHANNEL &&
                        !(it.turn_on && st.safe_latched))
                    begin
                        if (probe(it.now_ms, 1'b0, it.init_ok))
                        begin
                            if (it.access_ok)
                            begin
                                mask  = 8'd1 << it.channel[2:0];
                                level = cfg.energize_low ? !it.turn_on : it.turn_on;
                                drive_latch(level ? (st.output_shadow | mask)
                                                  : (st.output_shadow & ~mask));
                                mark_success();
                                cur.ok = 1'b1;
                            end
                            else
                                mark_failure(it.now_ms);
                        end
                    end
                end
                rexg_pkg::KIND_READ_CH:
                begin
                    if (it.channel <= rexg_pkg::LAST_VALID_CHANNEL)
                    begin
                        if (probe(it.now_ms, 1'b0, it.init_ok))
                        begin
                            if (it.channel <= rexg_pkg::LAST_OUTPUT_CHANNEL)
                            begin
                                logical = to_pin(st.output_shadow);
                                cur.read_value = {15'd0, logical[it.channel[2:0]]};
                                cur.ok = 1'b1;
                            end
                            else if (it.access_ok)
                            begin
                                cur.read_value = {15'd0, it.port_b_value[it.channel[2:0]]};
                                mark_success();
                                cur.ok = 1'b1;
                            end
                            else
                                mark_failure(it.now_ms);
                        end
                    end
                end
                rexg_pkg::KIND_READ_ALL:
                begin
                    if (probe(it.now_ms, 1'b0, it.init_ok))
                    begin
                        if (it.access_ok)
                        begin
                            cur.read_value = {it.port_b_value, to_pin(st.output_shadow)};
                            mark_success();
                            cur.ok = 1'b1;
                        end
                        else
                            mark_failure(it.now_ms);
                    end
                end
                rexg_pkg::KIND_ALL_SAFE, rexg_pkg::KIND_LATCH_SAFE:
                begin
                    if (it.kind == rexg_pkg::KIND_LATCH_SAFE)
                        st.safe_latched = 1'b1;
                    if (probe(it.now_ms, 1'b0, it.init_ok))
                    begin
                        if (it.access_ok)
                        begin
                            drive_latch(safe_pattern());
                            mark_success();
                            cur.ok = 1'b1;
                        end
                        else
                            mark_failure(it.now_ms);
                    end
                end
                default: ;
            endcase
            expected_results.push_back(cur);
        endfunction

        task report(string msg);
            $display("ERROR @%0t result %0d: %s", $time, result_seq, msg);
            fail_count++;
        endtask

        task check_result(rexg_pkg::result_t got);
            rexg_pkg::result_t want;
            result_seq++;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with no request outstanding (%h)", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.ok !== want.ok)
                report($sformatf("ok %b, expected %b", got.ok, want.ok));
            if (got.read_value !== want.read_value)
                report($sformatf("read_value %h, expected %h", got.read_value, want.read_value));
            if (got.latch_write !== want.latch_write)
                report($sformatf("latch_write %b, expected %b", got.latch_write,
                                 want.latch_write));
            if (got.latch_byte !== want.latch_byte)
                report($sformatf("latch_byte %h, expected %h", got.latch_byte, want.latch_byte));
            if (got.init_issued !== want.init_issued)
                report($sformatf("init_issued %b, expected %b", got.init_issued,
                                 want.init_issued));
        endtask
    endclass

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    rexg_req_if req_if();
    rexg_rsp_if rsp_if();

    relay_expander_guard_with_backoff u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    relay_guard_scoreboard sb = new();

    bit          burst_mode;
    int          stall_left;
    int          cycle_count;
    logic [31:0] clock_ms;
    int          iok_pct;
    int          aok_pct;
    int          step_max;
    bit          init_on;
    bit          latch_on;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int idle_length();
        return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end
        else if (!burst_mode && $urandom_range(0, 99) < 25)
        begin
            rsp_if.ready <= 1'b0;
            stall_left = idle_length() - 1;
        end
        else
            rsp_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_result('{ok: rsp_if.ok, read_value: rsp_if.read_value,
                              latch_write: rsp_if.latch_write,
                              latch_byte: rsp_if.latch_byte,
                              init_issued: rsp_if.init_issued});
    end

    task automatic push_request(input rexg_pkg::item_t it);
        int gap;
        if ($urandom_range(0, 99) < 3)
            burst_mode = !burst_mode;
        gap = (!burst_mode && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= it.kind;
        req_if.now_ms       <= it.now_ms;
        req_if.channel      <= it.channel;
        req_if.turn_on      <= it.turn_on;
        req_if.init_ok      <= it.init_ok;
        req_if.access_ok    <= it.access_ok;
        req_if.port_b_value <= it.port_b_value;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        sb.note_request(it);
    endtask

    task automatic drain();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input rexg_pkg::reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
    endtask

    task automatic configure(input rexg_pkg::cfg_t c);
        drain();
        write_reg(rexg_pkg::REG_ACTIVE_LOW, {31'd0, c.energize_low});
        write_reg(rexg_pkg::REG_SAFE_ON, {31'd0, c.relay_safe_on});
        write_reg(rexg_pkg::REG_RETRY_BASE, {16'd0, c.retry_base_ms});
        write_reg(rexg_pkg::REG_RETRY_MAX, c.retry_max_ms);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic rexg_pkg::item_t make_req(input logic [2:0] kind,
                                                 input logic [31:0] now,
                                                 input logic [3:0] ch, input bit on,
                                                 input bit iok, input bit aok,
                                                 input logic [7:0] pb);
        rexg_pkg::item_t it;
        it.kind         = kind;
        it.now_ms       = now;
        it.channel      = ch;
        it.turn_on      = on;
        it.init_ok      = iok;
        it.access_ok    = aok;
        it.port_b_value = pb;
        return it;
    endfunction

    function automatic rexg_pkg::item_t random_request();
        rexg_pkg::item_t it;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 70)
            clock_ms = clock_ms + $urandom_range(0, step_max);
        else if (r < 88)
            clock_ms = clock_ms + $urandom_range(0, 4 * step_max);
        else if (r < 96)
            clock_ms = clock_ms - $urandom_range(0, step_max);
        else
            clock_ms = $urandom;
        r = $urandom_range(0, 99);
        if (r < 4)
            it.kind = init_on ? rexg_pkg::KIND_INIT : rexg_pkg::KIND_QUERY;
        else if (r < 14)
            it.kind = rexg_pkg::KIND_QUERY;
        else if (r < 44)
            it.kind = rexg_pkg::KIND_WRITE;
        else if (r < 64)
            it.kind = rexg_pkg::KIND_READ_CH;
        else if (r < 79)
            it.kind = rexg_pkg::KIND_READ_ALL;
        else if (r < 93)
            it.kind = rexg_pkg::KIND_ALL_SAFE;
        else if (r < 98)
            it.kind = latch_on ? rexg_pkg::KIND_LATCH_SAFE : rexg_pkg::KIND_ALL_SAFE;
        else
            it.kind = KIND_UNUSED;
        it.now_ms = clock_ms;
        if (it.kind == rexg_pkg::KIND_WRITE && $urandom_range(0, 99) < 85)
            it.channel = 4'($urandom_range(0, 7));
        else
            it.channel = 4'($urandom_range(0, 15));
        it.turn_on      = 1'($urandom_range(0, 1));
        it.init_ok      = $urandom_range(0, 99) < iok_pct;
        it.access_ok    = $urandom_range(0, 99) < aok_pct;
        it.port_b_value = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic run_phase(input int n, input int iok, input int aok, input int step,
                             input bit with_init, input bit with_latch,
                             input logic [31:0] start_ms);
        clock_ms = start_ms;
        iok_pct  = iok;
        aok_pct  = aok;
        step_max = step;
        init_on  = with_init;
        latch_on = with_latch;
        repeat (n) push_request(random_request());
    endtask

    initial
    begin
        req_if.valid        = 1'b0;
        req_if.kind         = rexg_pkg::KIND_INIT;
        req_if.now_ms       = 32'd0;
        req_if.channel      = 4'd0;
        req_if.turn_on      = 1'b0;
        req_if.init_ok      = 1'b0;
        req_if.access_ok    = 1'b0;
        req_if.port_b_value = 8'd0;
        rsp_if.ready        = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_index           = rexg_pkg::REG_ACTIVE_LOW;
        cfg_wdata           = 32'd0;
        burst_mode          = 1'b0;
        stall_left          = 0;
        cycle_count         = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: active-low pins, safe pattern all off, 500 / 30000 ms
        push_request(make_req(KIND_UNUSED, 32'd0, 4'd0, 1'b0, 1'b1, 1'b1, 8'hFF));
        push_request(make_req(rexg_pkg::KIND_QUERY, 32'd0, 4'd0, 1'b0, 1'b0, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_QUERY, 32'd100, 4'd0, 1'b0, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd499, 4'd3, 1'b1, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_QUERY, 32'd500, 4'd0, 1'b0, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd510, 4'd0, 1'b1, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd520, 4'd7, 1'b1, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd530, 4'd7, 1'b0, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd540, 4'd8, 1'b1, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd600, 4'd5, 1'b1, 1'b1, 1'b0, 8'h00));
        push_request(make_req(rexg_pkg::KIND_READ_CH, 32'd700, 4'd0, 1'b0, 1'b1, 1'b1,
                              8'h00));
        push_request(make_req(rexg_pkg::KIND_READ_CH, 32'd1100, 4'd0, 1'b0, 1'b1, 1'b1,
                              8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd1110, 4'd2, 1'b1, 1'b0, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_READ_CH, 32'd1120, 4'd2, 1'b0, 1'b0, 1'b0,
                              8'h00));
        push_request(make_req(rexg_pkg::KIND_READ_CH, 32'd1130, 4'd8, 1'b0, 1'b0, 1'b1,
                              8'hA5));
        push_request(make_req(rexg_pkg::KIND_READ_CH, 32'd1140, 4'd15, 1'b0, 1'b0, 1'b1,
                              8'h80));
        push_request(make_req(rexg_pkg::KIND_READ_CH, 32'd1200, 4'd12, 1'b0, 1'b1, 1'b0,
                              8'hFF));
        push_request(make_req(rexg_pkg::KIND_READ_ALL, 32'd1700, 4'd0, 1'b0, 1'b1, 1'b1,
                              8'h5A));
        push_request(make_req(rexg_pkg::KIND_READ_ALL, 32'd1800, 4'd0, 1'b0, 1'b1, 1'b0,
                              8'hC3));
        push_request(make_req(rexg_pkg::KIND_ALL_SAFE, 32'hFFFF_FFFF, 4'd0, 1'b0, 1'b1,
                              1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_INIT, 32'hFFFF_FFFF, 4'd0, 1'b0, 1'b0, 1'b1,
                              8'h00));
        push_request(make_req(rexg_pkg::KIND_QUERY, 32'h0000_0100, 4'd0, 1'b0, 1'b1, 1'b1,
                              8'h00));
        push_request(make_req(rexg_pkg::KIND_ALL_SAFE, 32'd499, 4'd0, 1'b0, 1'b1, 1'b0,
                              8'h00));
        push_request(make_req(rexg_pkg::KIND_INIT, 32'd0, 4'd0, 1'b0, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_ALL_SAFE, 32'd10, 4'd0, 1'b0, 1'b1, 1'b1,
                              8'h00));

        configure('{1'b1, 1'b0, 16'd500, 32'd30000});
        run_phase(300, 70, 85, 400, 1'b1, 1'b0, 32'd5000);

        // flaky bus across the wrap of the millisecond clock
        configure('{1'b0, 1'b1, 16'd1, 32'hFFFF_FFFF});
        run_phase(200, 50, 70, 40, 1'b1, 1'b0, 32'hFFFF_FE00);

        // dead device: error count climbs, short delays keep probing
        configure('{1'b1, 1'b1, 16'd3, 32'd100});
        run_phase(320, 1, 10, 200, 1'b0, 1'b0, 32'h8000_0000);

        configure('{1'b1, 1'b0, 16'hFFFF, 32'hFFFF_FFFF});
        run_phase(60, 40, 60, 5000000, 1'b1, 1'b0, 32'd0);

        configure('{1'b0, 1'b0, 16'd0, 32'd0});
        run_phase(90, 40, 60, 10, 1'b1, 1'b0, 32'h7FFF_FFF0);

        configure('{1'b1, 1'b1, 16'd700, 32'd5000});
        push_request(make_req(rexg_pkg::KIND_INIT, 32'd100, 4'd0, 1'b0, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_LATCH_SAFE, 32'd110, 4'd0, 1'b0, 1'b1, 1'b1,
                              8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd120, 4'd4, 1'b1, 1'b1, 1'b1, 8'h00));
        push_request(make_req(rexg_pkg::KIND_WRITE, 32'd130, 4'd4, 1'b0, 1'b1, 1'b1, 8'h00));
        run_phase(250, 75, 85, 3000, 1'b1, 1'b1, 32'd200);

        drain();
        repeat (8) @(posedge clk);
        if (sb.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
